// ----- design/vvcc_to_annexb_converter_defines.svh -----
`ifndef VVCC_TO_ANNEXB_CONVERTER_DEFINES_SVH
`define VVCC_TO_ANNEXB_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define VTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vta_pkg.sv -----
`timescale 1ns / 1ps

package vta_pkg;

  localparam int SIZE_BITS = 16;
  localparam int CFG_W     = 16;
  localparam int SUM_W     = ((SIZE_BITS > CFG_W) ? SIZE_BITS : CFG_W) + 1;

  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int APB_IDX_LSB = 2;
  localparam logic [APB_AW-APB_IDX_LSB-1:0] REG_TOTAL_SIZE = '0;

  localparam int FIFO_DEPTH = 4;

  localparam int SC_LEN   = 4;
  localparam int SC_CNT_W = $clog2(SC_LEN);
  localparam logic [SC_CNT_W-1:0] SC_LAST = SC_CNT_W'(SC_LEN - 1);
  localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [7:0] SC_ONE_BYTE  = 8'h01;

  localparam logic [CFG_W-1:0] MIN_RECORD = CFG_W'(3);
  localparam int LVL_FLAG_BITS = 6;
  localparam logic [4:0] NAL_TYPE_OPI = 5'd12;
  localparam logic [4:0] NAL_TYPE_DCI = 5'd13;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  typedef enum logic [15:0] {
    PH_FLAG      = 16'b0000_0000_0000_0001,
    PH_PTL_HDR   = 16'b0000_0000_0000_0010,
    PH_PTL_CI    = 16'b0000_0000_0000_0100,
    PH_SKIP_PTL  = 16'b0000_0000_0000_1000,
    PH_FLAGS     = 16'b0000_0000_0001_0000,
    PH_SKIP_LVL  = 16'b0000_0000_0010_0000,
    PH_SUBPROF   = 16'b0000_0000_0100_0000,
    PH_SKIP_TAIL = 16'b0000_0000_1000_0000,
    PH_NUMARR    = 16'b0000_0001_0000_0000,
    PH_ARR_TYPE  = 16'b0000_0010_0000_0000,
    PH_CNT_HI    = 16'b0000_0100_0000_0000,
    PH_CNT_LO    = 16'b0000_1000_0000_0000,
    PH_LEN_HI    = 16'b0001_0000_0000_0000,
    PH_LEN_LO    = 16'b0010_0000_0000_0000,
    PH_PAYLOAD   = 16'b0100_0000_0000_0000,
    PH_DONE      = 16'b1000_0000_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } cmd_t;

endpackage

// ----- design/vvcc_to_annexb_converter.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake                     Beat
// in_      in   in_valid / in_ready           in_data: in_byte, in_last
// out_     out  out_valid / out_ready         out_data: out_byte, byte_valid, out_last, status
// cfg      in   psel penable pwrite / pready  total_size at byte address 0
//
// One record byte per cycle; a NAL length byte expands to four start-code beats,
// which the output side emits while the input keeps going.
// Input stalls only while the four-entry command queue between parser and emitter is full.
// An output beat passes through the command queue and then the output register after its input beat is accepted.
// Synchronous reset clears parser, queue pointers, output valid, start-code counter and total_size.

module vvcc_to_annexb_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  vta_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vta_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vta_pkg::APB_AW-1:0]  paddr,
  input  logic [vta_pkg::APB_DW-1:0]  pwdata,
  output logic [vta_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [vta_pkg::CFG_W-1:0] total_size_r;
  logic                      reg_sel;
  logic                      push, pop, full, head_valid;
  vta_pkg::cmd_t             push_cmd, head;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[vta_pkg::APB_AW-1:vta_pkg::APB_IDX_LSB] == vta_pkg::REG_TOTAL_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      total_size_r <= pwdata[vta_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = vta_pkg::APB_DW'(total_size_r);
    end
  end

  vta_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .total_size (total_size_r),
    .fifo_full  (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  vta_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  vta_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- design/vta_front.sv -----
`timescale 1ns / 1ps
`include "vvcc_to_annexb_converter_defines.svh"

module vta_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vta_pkg::in_item_t          in_data,
  input  logic [vta_pkg::CFG_W-1:0]  total_size,
  input  logic                       fifo_full,
  output logic                       push,
  output vta_pkg::cmd_t              push_cmd
);

  vta_pkg::phase_t                 phase_r, phase_nxt;
  logic [vta_pkg::SIZE_BITS-1:0]   pos_r, pos_nxt, pos_inc;
  logic [2:0]                      sc_r, sc_nxt;
  logic [15:0]                     skip_r, skip_nxt;
  logic [7:0]                      arrays_r, arrays_nxt;
  logic [15:0]                     nals_r, nals_nxt;
  logic [7:0]                      hi_r, hi_nxt;
  logic                            produced_r, produced_nxt;
  logic                            trunc_r, trunc_nxt;

  logic                            acc;
  logic [7:0]                      b;
  logic [15:0]                     word;
  logic [2:0]                      lvl_cnt;
  logic [vta_pkg::CFG_W-1:0]       addend, nd_addend;
  logic                            fits, nd_fits;
  logic                            gen;
  vta_pkg::cmd_kind_t              gen_kind;
  logic                            final_trunc;

  assign in_ready = !fifo_full;
  assign acc      = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign word     = {hi_r, b};
  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  always_comb begin
    lvl_cnt = '0;
    for (int k = 0; k < vta_pkg::LVL_FLAG_BITS; k++) begin
      if ((4'(k) + 4'd1 < {1'b0, sc_r}) && b[7-k]) begin
        lvl_cnt = lvl_cnt + 3'd1;
      end
    end
  end

  always_comb begin
    unique case (phase_r)
      vta_pkg::PH_FLAG:     addend = b[0] ? 16'd2 : 16'd1;
      vta_pkg::PH_PTL_CI:   addend = 16'(b[5:0]) + 16'd1;
      vta_pkg::PH_FLAGS:    addend = 16'(lvl_cnt) + 16'd1;
      vta_pkg::PH_SUBPROF:  addend = 16'({b, 2'b00}) + 16'd6;
      vta_pkg::PH_NUMARR:   addend = 16'd3;
      vta_pkg::PH_ARR_TYPE: addend = 16'd2;
      vta_pkg::PH_CNT_LO:   addend = (word == '0) ? 16'd3 : 16'd2;
      vta_pkg::PH_LEN_LO:   addend = word;
      default:              addend = 16'd1;
    endcase
  end

  assign nd_addend = (nals_r == 16'd1) ? 16'd3 : 16'd2;
  assign fits    = (vta_pkg::SUM_W'(pos_inc) + vta_pkg::SUM_W'(addend))
                   <= vta_pkg::SUM_W'(total_size);
  assign nd_fits = (vta_pkg::SUM_W'(pos_inc) + vta_pkg::SUM_W'(nd_addend))
                   <= vta_pkg::SUM_W'(total_size);

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    sc_nxt       = sc_r;
    skip_nxt     = skip_r;
    arrays_nxt   = arrays_r;
    nals_nxt     = nals_r;
    hi_nxt       = hi_r;
    produced_nxt = produced_r;
    trunc_nxt    = trunc_r;
    gen          = 1'b0;
    gen_kind     = vta_pkg::CMD_DATA;

    if (phase_r != vta_pkg::PH_DONE) begin
      pos_nxt = pos_inc;
    end

    unique case (phase_r)
      vta_pkg::PH_FLAG: begin
        if (total_size < vta_pkg::MIN_RECORD) begin
          phase_nxt = vta_pkg::PH_DONE;
        end else begin
          if (b[0]) begin
            skip_nxt = 16'd2;
          end
          phase_nxt = !fits ? vta_pkg::PH_DONE :
                      b[0] ? vta_pkg::PH_PTL_HDR : vta_pkg::PH_NUMARR;
          trunc_nxt = trunc_r | !fits;
        end
      end
      vta_pkg::PH_PTL_HDR: begin
        if (skip_r == 16'd1) begin
          sc_nxt = b[6:4];
        end
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == '0) begin
          phase_nxt = fits ? vta_pkg::PH_PTL_CI : vta_pkg::PH_DONE;
          trunc_nxt = trunc_r | !fits;
        end
      end
      vta_pkg::PH_PTL_CI: begin
        skip_nxt  = 16'(b[5:0]) + 16'd1;
        phase_nxt = fits ? vta_pkg::PH_SKIP_PTL : vta_pkg::PH_DONE;
        trunc_nxt = trunc_r | !fits;
      end
      vta_pkg::PH_SKIP_PTL: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == '0) begin
          phase_nxt = !fits ? vta_pkg::PH_DONE :
                      (sc_r > 3'd1) ? vta_pkg::PH_FLAGS : vta_pkg::PH_SUBPROF;
          trunc_nxt = trunc_r | !fits;
        end
      end
      vta_pkg::PH_FLAGS: begin
        skip_nxt  = 16'(lvl_cnt);
        phase_nxt = !fits ? vta_pkg::PH_DONE :
                    (lvl_cnt != '0) ? vta_pkg::PH_SKIP_LVL : vta_pkg::PH_SUBPROF;
        trunc_nxt = trunc_r | !fits;
      end
      vta_pkg::PH_SKIP_LVL: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == '0) begin
          phase_nxt = fits ? vta_pkg::PH_SUBPROF : vta_pkg::PH_DONE;
          trunc_nxt = trunc_r | !fits;
        end
      end
      vta_pkg::PH_SUBPROF: begin
        skip_nxt  = addend;
        phase_nxt = fits ? vta_pkg::PH_SKIP_TAIL : vta_pkg::PH_DONE;
        trunc_nxt = trunc_r | !fits;
      end
      vta_pkg::PH_SKIP_TAIL: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == '0) begin
          phase_nxt = fits ? vta_pkg::PH_NUMARR : vta_pkg::PH_DONE;
          trunc_nxt = trunc_r | !fits;
        end
      end
      vta_pkg::PH_NUMARR: begin
        arrays_nxt = b;
        phase_nxt  = (b == '0 || !fits) ? vta_pkg::PH_DONE : vta_pkg::PH_ARR_TYPE;
      end
      vta_pkg::PH_ARR_TYPE: begin
        arrays_nxt = arrays_r - 8'd1;
        if (b[4:0] == vta_pkg::NAL_TYPE_OPI || b[4:0] == vta_pkg::NAL_TYPE_DCI) begin
          nals_nxt  = 16'd1;
          phase_nxt = fits ? vta_pkg::PH_LEN_HI : vta_pkg::PH_DONE;
          trunc_nxt = trunc_r | !fits;
        end else begin
          phase_nxt = vta_pkg::PH_CNT_HI;
        end
      end
      vta_pkg::PH_CNT_HI: begin
        hi_nxt    = b;
        phase_nxt = vta_pkg::PH_CNT_LO;
      end
      vta_pkg::PH_CNT_LO: begin
        nals_nxt = word;
        if (word == '0) begin
          phase_nxt = (arrays_r == '0 || !fits) ? vta_pkg::PH_DONE : vta_pkg::PH_ARR_TYPE;
        end else begin
          phase_nxt = fits ? vta_pkg::PH_LEN_HI : vta_pkg::PH_DONE;
          trunc_nxt = trunc_r | !fits;
        end
      end
      vta_pkg::PH_LEN_HI: begin
        hi_nxt    = b;
        phase_nxt = vta_pkg::PH_LEN_LO;
      end
      vta_pkg::PH_LEN_LO: begin
        if (!fits) begin
          phase_nxt = vta_pkg::PH_DONE;
          trunc_nxt = 1'b1;
        end else begin
          gen          = 1'b1;
          gen_kind     = vta_pkg::CMD_START;
          produced_nxt = 1'b1;
          if (word == '0) begin
            nals_nxt = nals_r - 16'd1;
            if (nals_r != 16'd1) begin
              phase_nxt = nd_fits ? vta_pkg::PH_LEN_HI : vta_pkg::PH_DONE;
              trunc_nxt = trunc_r | !nd_fits;
            end else begin
              phase_nxt = (arrays_r == '0 || !nd_fits) ? vta_pkg::PH_DONE
                                                      : vta_pkg::PH_ARR_TYPE;
            end
          end else begin
            skip_nxt  = word;
            phase_nxt = vta_pkg::PH_PAYLOAD;
          end
        end
      end
      vta_pkg::PH_PAYLOAD: begin
        gen      = 1'b1;
        gen_kind = vta_pkg::CMD_DATA;
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == '0) begin
          nals_nxt = nals_r - 16'd1;
          if (nals_r != 16'd1) begin
            phase_nxt = nd_fits ? vta_pkg::PH_LEN_HI : vta_pkg::PH_DONE;
            trunc_nxt = trunc_r | !nd_fits;
          end else begin
            phase_nxt = (arrays_r == '0 || !nd_fits) ? vta_pkg::PH_DONE
                                                    : vta_pkg::PH_ARR_TYPE;
          end
        end
      end
      vta_pkg::PH_DONE: begin
        phase_nxt = vta_pkg::PH_DONE;
      end
      default: begin
        phase_nxt = vta_pkg::PH_DONE;
      end
    endcase
  end

  assign final_trunc = trunc_nxt | (phase_nxt != vta_pkg::PH_DONE);

  always_comb begin
    push_cmd.kind   = gen ? gen_kind : vta_pkg::CMD_END;
    push_cmd.data   = b;
    push_cmd.last   = in_data.in_last;
    push_cmd.status = vta_pkg::ST_OK;
    if (in_data.in_last) begin
      push_cmd.status = !produced_nxt ? vta_pkg::ST_NONE :
                        final_trunc   ? vta_pkg::ST_TRUNC : vta_pkg::ST_OK;
    end
  end

  assign push = acc && (gen || in_data.in_last);

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_data.in_last)) begin
      phase_r    <= vta_pkg::PH_FLAG;
      pos_r      <= '0;
      sc_r       <= '0;
      skip_r     <= '0;
      arrays_r   <= '0;
      nals_r     <= '0;
      hi_r       <= '0;
      produced_r <= 1'b0;
      trunc_r    <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      sc_r       <= sc_nxt;
      skip_r     <= skip_nxt;
      arrays_r   <= arrays_nxt;
      nals_r     <= nals_nxt;
      hi_r       <= hi_nxt;
      produced_r <= produced_nxt;
      trunc_r    <= trunc_nxt;
    end
  end

  `VTA_ASSERT_NEXT(a_last_restarts, acc && in_data.in_last, phase_r == vta_pkg::PH_FLAG, "parser did not restart after final byte")
  `VTA_ASSERT_NOW(a_flag_at_zero, phase_r == vta_pkg::PH_FLAG, pos_r == '0, "byte position not zero in flag phase")
  `VTA_ASSERT_NOW(a_start_marks_produced, push && push_cmd.kind == vta_pkg::CMD_START, produced_nxt, "start code without produced mark")

endmodule

// ----- design/vta_fifo.sv -----
`timescale 1ns / 1ps
`include "vvcc_to_annexb_converter_defines.svh"

module vta_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vta_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output vta_pkg::cmd_t head
);

  localparam int PTR_W = $clog2(vta_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(vta_pkg::FIFO_DEPTH + 1);

  vta_pkg::cmd_t    mem_r [vta_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(vta_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `VTA_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
  `VTA_ASSERT_NOW(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

// ----- design/vta_back.sv -----
`timescale 1ns / 1ps
`include "vvcc_to_annexb_converter_defines.svh"

module vta_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  vta_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output vta_pkg::out_item_t out_data
);

  logic                          out_valid_r, out_valid_nxt;
  vta_pkg::out_item_t            out_data_r, out_data_nxt;
  logic [vta_pkg::SC_CNT_W-1:0]  sc_cnt_r, sc_cnt_nxt;
  logic                          load;
  logic                          sc_end;

  assign load   = !out_valid_r || out_ready;
  assign sc_end = (sc_cnt_r == vta_pkg::SC_LAST);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sc_cnt_nxt    = sc_cnt_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        unique case (head.kind)
          vta_pkg::CMD_START: begin
            out_data_nxt.out_byte   = sc_end ? vta_pkg::SC_ONE_BYTE : vta_pkg::SC_ZERO_BYTE;
            out_data_nxt.byte_valid = 1'b1;
            out_data_nxt.out_last   = sc_end && head.last;
            out_data_nxt.status     = sc_end ? head.status : vta_pkg::ST_OK;
            sc_cnt_nxt              = sc_cnt_r + 1'b1;
            pop                     = sc_end;
          end
          vta_pkg::CMD_DATA: begin
            out_data_nxt.out_byte   = head.data;
            out_data_nxt.byte_valid = 1'b1;
            out_data_nxt.out_last   = head.last;
            out_data_nxt.status     = head.status;
            pop                     = 1'b1;
          end
          vta_pkg::CMD_END: begin
            out_data_nxt.out_byte   = vta_pkg::SC_ZERO_BYTE;
            out_data_nxt.byte_valid = 1'b0;
            out_data_nxt.out_last   = 1'b1;
            out_data_nxt.status     = head.status;
            pop                     = 1'b1;
          end
          default: begin
            out_valid_nxt = 1'b0;
            pop           = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sc_cnt_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sc_cnt_r    <= sc_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VTA_ASSERT_NOW(a_sc_mid_on_start, sc_cnt_r != '0, head_valid && head.kind == vta_pkg::CMD_START, "start code split from its command")
  `VTA_ASSERT_NOW(a_status_only_last, out_valid_r && !out_data_r.out_last, out_data_r.status == vta_pkg::ST_OK, "status set on non-final beat")

endmodule

// ----- test/tb_vvcc_to_annexb_converter.sv -----
`timescale 1ns / 1ps

module tb_vvcc_to_annexb_converter;

  localparam int RUN_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam longint POS_MAX = (longint'(1) << vta_pkg::SIZE_BITS) - 1;
  localparam logic [vta_pkg::APB_AW-vta_pkg::APB_IDX_LSB-1:0] REG_SPARE =
    ~vta_pkg::REG_TOTAL_SIZE;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vta_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vta_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [vta_pkg::APB_AW-1:0] paddr = '0;
  logic [vta_pkg::APB_DW-1:0] pwdata = '0;
  logic [vta_pkg::APB_DW-1:0] prdata;
  logic pready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int err_cnt = 0;
  int unsigned cycle_cnt = 0;

  logic [vta_pkg::CFG_W-1:0] rec_total = '0;
  vta_pkg::phase_t ps_phase;
  longint ps_pos;
  int ps_sublayers, ps_skip, ps_lvl_flags, ps_sub_idx, ps_arrays, ps_nals, ps_hi;
  logic ps_emitted, ps_trunc;

  vta_pkg::out_item_t annexb_expected[$];
  logic [7:0] rec_bytes[$];

  vvcc_to_annexb_converter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("tb_vvcc_to_annexb_converter: errors");
      $finish;
    end
  end

  // hold off for a counted stretch, otherwise stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    vta_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (annexb_expected.size() == 0) begin
        report_mismatch($sformatf("beat %h with nothing expected", out_data));
      end else begin
        want = annexb_expected.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_data.out_byte, want.out_byte));
        if (out_data.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b",
                                    out_data.byte_valid, want.byte_valid));
        if (out_data.out_last !== want.out_last)
          report_mismatch($sformatf("out_last %b, want %b", out_data.out_last, want.out_last));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
      end
    end
  end

  function automatic void parse_clear();
    ps_phase = vta_pkg::PH_FLAG;
    ps_pos = 0;
    ps_sublayers = 0;
    ps_skip = 0;
    ps_lvl_flags = 0;
    ps_sub_idx = 0;
    ps_arrays = 0;
    ps_nals = 0;
    ps_hi = 0;
    ps_emitted = 1'b0;
    ps_trunc = 1'b0;
  endfunction

  function automatic void need_bytes(input longint end_pos, input vta_pkg::phase_t nxt);
    if (end_pos > longint'(rec_total)) begin
      ps_phase = vta_pkg::PH_DONE;
      ps_trunc = 1'b1;
    end else begin
      ps_phase = nxt;
    end
  endfunction

  function automatic void next_array(input longint pos);
    if (ps_arrays == 0 || pos + 3 > longint'(rec_total)) ps_phase = vta_pkg::PH_DONE;
    else ps_phase = vta_pkg::PH_ARR_TYPE;
  endfunction

  function automatic void close_nal(input longint pos);
    ps_nals = (ps_nals - 1) & 'hffff;
    if (ps_nals != 0) need_bytes(pos + 2, vta_pkg::PH_LEN_HI);
    else next_array(pos);
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic v);
    vta_pkg::out_item_t beat;
    beat.out_byte = b;
    beat.byte_valid = v;
    beat.out_last = 1'b0;
    beat.status = vta_pkg::ST_OK;
    annexb_expected.push_back(beat);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int bi, k, cnt, nal_type;
    longint pos, len;
    if (ps_phase == vta_pkg::PH_DONE) return;
    bi = b;
    if (ps_pos < POS_MAX) ps_pos++;
    pos = ps_pos;
    case (ps_phase)
      vta_pkg::PH_FLAG: begin
        if (rec_total < vta_pkg::MIN_RECORD) begin
          ps_phase = vta_pkg::PH_DONE;
        end else if (b[0]) begin
          ps_skip = 2;
          need_bytes(pos + 2, vta_pkg::PH_PTL_HDR);
        end else begin
          need_bytes(pos + 1, vta_pkg::PH_NUMARR);
        end
      end
      vta_pkg::PH_PTL_HDR: begin
        if (ps_skip == 1) ps_sublayers = (bi >> 4) & 'h7;
        ps_skip = (ps_skip - 1) & 'hffff;
        if (ps_skip == 0) need_bytes(pos + 1, vta_pkg::PH_PTL_CI);
      end
      vta_pkg::PH_PTL_CI: begin
        k = bi & 'h3f;
        ps_skip = k + 1;
        need_bytes(pos + k + 1, vta_pkg::PH_SKIP_PTL);
      end
      vta_pkg::PH_SKIP_PTL: begin
        ps_skip = (ps_skip - 1) & 'hffff;
        if (ps_skip == 0)
          need_bytes(pos + 1, (ps_sublayers > 1) ? vta_pkg::PH_FLAGS : vta_pkg::PH_SUBPROF);
      end
      vta_pkg::PH_FLAGS: begin
        ps_lvl_flags = bi;
        cnt = 0;
        for (k = 0; k + 1 < ps_sublayers; k++)
          if (b[7-k]) cnt++;
        ps_sub_idx = 0;
        ps_skip = cnt;
        need_bytes(pos + cnt + 1, (cnt != 0) ? vta_pkg::PH_SKIP_LVL : vta_pkg::PH_SUBPROF);
      end
      vta_pkg::PH_SKIP_LVL: begin
        ps_sub_idx = (ps_sub_idx + 1) & 'h7;
        ps_skip = (ps_skip - 1) & 'hffff;
        if (ps_skip == 0) need_bytes(pos + 1, vta_pkg::PH_SUBPROF);
      end
      vta_pkg::PH_SUBPROF: begin
        ps_skip = 4 * bi + 6;
        need_bytes(pos + ps_skip, vta_pkg::PH_SKIP_TAIL);
      end
      vta_pkg::PH_SKIP_TAIL: begin
        ps_skip = (ps_skip - 1) & 'hffff;
        if (ps_skip == 0) need_bytes(pos + 1, vta_pkg::PH_NUMARR);
      end
      vta_pkg::PH_NUMARR: begin
        ps_arrays = bi;
        next_array(pos);
      end
      vta_pkg::PH_ARR_TYPE: begin
        ps_arrays = (ps_arrays - 1) & 'hff;
        nal_type = bi & 'h1f;
        if (nal_type == vta_pkg::NAL_TYPE_OPI || nal_type == vta_pkg::NAL_TYPE_DCI) begin
          ps_nals = 1;
          need_bytes(pos + 2, vta_pkg::PH_LEN_HI);
        end else begin
          ps_phase = vta_pkg::PH_CNT_HI;
        end
      end
      vta_pkg::PH_CNT_HI: begin
        ps_hi = bi;
        ps_phase = vta_pkg::PH_CNT_LO;
      end
      vta_pkg::PH_CNT_LO: begin
        ps_nals = (ps_hi << 8) | bi;
        if (ps_nals == 0) next_array(pos);
        else need_bytes(pos + 2, vta_pkg::PH_LEN_HI);
      end
      vta_pkg::PH_LEN_HI: begin
        ps_hi = bi;
        ps_phase = vta_pkg::PH_LEN_LO;
      end
      vta_pkg::PH_LEN_LO: begin
        len = (ps_hi << 8) | bi;
        if (pos + len > longint'(rec_total)) begin
          ps_phase = vta_pkg::PH_DONE;
          ps_trunc = 1'b1;
        end else begin
          push_beat(vta_pkg::SC_ZERO_BYTE, 1'b1);
          push_beat(vta_pkg::SC_ZERO_BYTE, 1'b1);
          push_beat(vta_pkg::SC_ZERO_BYTE, 1'b1);
          push_beat(vta_pkg::SC_ONE_BYTE, 1'b1);
          ps_emitted = 1'b1;
          if (len == 0) begin
            close_nal(pos);
          end else begin
            ps_skip = int'(len);
            ps_phase = vta_pkg::PH_PAYLOAD;
          end
        end
      end
      vta_pkg::PH_PAYLOAD: begin
        push_beat(b, 1'b1);
        ps_skip = (ps_skip - 1) & 'hffff;
        if (ps_skip == 0) close_nal(pos);
      end
      default: ps_phase = vta_pkg::PH_DONE;
    endcase
  endfunction

  function automatic void annexb_predict(input logic [7:0] b, input logic last);
    int n0;
    logic [1:0] st;
    vta_pkg::out_item_t tail;
    n0 = annexb_expected.size();
    parse_byte(b);
    if (last) begin
      if (ps_phase != vta_pkg::PH_DONE) ps_trunc = 1'b1;
      if (annexb_expected.size() == n0) push_beat(8'h00, 1'b0);
      if (!ps_emitted) st = vta_pkg::ST_NONE;
      else if (ps_trunc) st = vta_pkg::ST_TRUNC;
      else st = vta_pkg::ST_OK;
      tail = annexb_expected.pop_back();
      tail.out_last = 1'b1;
      tail.status = st;
      annexb_expected.push_back(tail);
      parse_clear();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_data <= '{in_byte: b, in_last: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    annexb_predict(b, last);
    bytes_sent++;
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_bytes.size(); i++)
      send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (annexb_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [vta_pkg::APB_AW-vta_pkg::APB_IDX_LSB-1:0] idx,
                           input logic [vta_pkg::APB_DW-1:0] value);
    paddr <= {idx, {vta_pkg::APB_IDX_LSB{1'b0}}};
    pwdata <= value;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == vta_pkg::REG_TOTAL_SIZE) rec_total = value[vta_pkg::CFG_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_total(input int value);
    if (value != int'(rec_total)) begin
      settle();
      cfg_write(vta_pkg::REG_TOTAL_SIZE, value);
    end
  endtask

  function automatic void push_random(input int n);
    repeat (n) rec_bytes.push_back(8'($urandom));
  endfunction

  function automatic void build_record();
    logic [7:0] b;
    int nsub, ci, cnt, nsp, narr, nn, len, tt;
    rec_bytes.delete();
    b = $urandom;
    b[0] = ($urandom_range(0, 2) == 0);
    rec_bytes.push_back(b);
    if (b[0]) begin
      push_random(1);
      nsub = $urandom_range(0, 7);
      b = $urandom;
      b[6:4] = nsub;
      rec_bytes.push_back(b);
      ci = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
      b = $urandom;
      b[5:0] = ci;
      rec_bytes.push_back(b);
      push_random(ci + 1);
      if (nsub > 1) begin
        b = $urandom;
        rec_bytes.push_back(b);
        cnt = 0;
        for (int k = 0; k + 1 < nsub; k++)
          if (b[7-k]) cnt++;
        push_random(cnt);
      end
      nsp = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
      rec_bytes.push_back(8'(nsp));
      push_random(4 * nsp + 6);
    end
    narr = $urandom_range(0, 2);
    rec_bytes.push_back(8'(narr));
    repeat (narr) begin
      b = $urandom;
      case ($urandom_range(0, 3))
        0: b[4:0] = vta_pkg::NAL_TYPE_OPI;
        1: b[4:0] = vta_pkg::NAL_TYPE_DCI;
        default: ;
      endcase
      rec_bytes.push_back(b);
      tt = b[4:0];
      if (tt == vta_pkg::NAL_TYPE_OPI || tt == vta_pkg::NAL_TYPE_DCI) begin
        nn = 1;
      end else begin
        nn = $urandom_range(0, 2);
        rec_bytes.push_back(8'(nn >> 8));
        rec_bytes.push_back(8'(nn));
      end
      repeat (nn) begin
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        rec_bytes.push_back(8'(len >> 8));
        rec_bytes.push_back(8'(len));
        push_random(len);
      end
    end
  endfunction

  task automatic test_short_record();
    cfg_write(vta_pkg::REG_TOTAL_SIZE, 32'h0000_0000);
    cfg_write(REG_SPARE, 32'h0000_ffff);
    rec_bytes = '{8'hff};
    send_record();
  endtask

  task automatic test_zero_length_nal();
    settle();
    cfg_write(vta_pkg::REG_TOTAL_SIZE, 32'hffff_ffff);
    rec_bytes = '{8'hfe, 8'h01, 8'hed, 8'h00, 8'h00, 8'hff};
    send_record();
  endtask

  task automatic test_length_overflow();
    rec_bytes = '{8'h00, 8'h01, 8'h01, 8'h00, 8'h01, 8'hff, 8'hff};
    send_record();
  endtask

  task automatic test_level_overrun();
    set_total(8);
    rec_bytes = '{8'h01, 8'h00, 8'h20, 8'h00, 8'h00, 8'h80, 8'haa, 8'h00};
    send_record();
  endtask

  task automatic test_early_end();
    set_total(65535);
    rec_bytes = '{8'h00, 8'h01, 8'h0c, 8'h00, 8'h03, 8'haa, 8'h55};
    send_record();
  endtask

  task automatic test_random_records(input int tx_pct, input int rx_pct, input int n_bytes);
    int stop_at, kind, ts, cut;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
        rec_bytes.delete();
        push_random($urandom_range(1, 8));
        ts = $urandom_range(0, 40);
      end else begin
        build_record();
        ts = rec_bytes.size() + $urandom_range(0, 2);
        if (kind == 6) ts = $urandom_range(0, rec_bytes.size() - 1);
        if (kind == 9) ts = 65535;
        if (kind < 6 && int'(rec_total) >= rec_bytes.size() && $urandom_range(0, 1))
          ts = rec_total;
        if (kind == 7) begin
          cut = $urandom_range(1, rec_bytes.size());
          while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
        end
      end
      set_total(ts);
      send_record();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_total(65535);
    rec_bytes = '{8'h00, 8'h01, 8'h01, 8'h00, 8'h02};
    repeat (2) begin
      rec_bytes.push_back(8'h00);
      rec_bytes.push_back(8'd20);
      push_random(20);
    end
    hold_left = 300;
    send_record();
    settle();
  endtask

  initial begin
    parse_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_record();
    test_zero_length_nal();
    test_length_overflow();
    test_level_overrun();
    test_early_end();
    test_random_records(10, 51, 40);
    test_random_records(51, 10, 40);
    test_random_records(0, 0, 40);
    test_backpressure();
    settle();
    if (err_cnt == 0) begin
      $display("tb_vvcc_to_annexb_converter: clean");
    end else begin
      $display("tb_vvcc_to_annexb_converter: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/vta_pkg.sv
design/vta_front.sv
design/vta_fifo.sv
design/vta_back.sv
design/vvcc_to_annexb_converter.sv
test/tb_vvcc_to_annexb_converter.sv
